/* sv/snm_pkg.sv */
// Shared types for the Sobel height-to-normal-map block.
`timescale 1ns / 1ps
package snm_pkg;

	// One window column, index 0 is the top row.
	typedef logic [2:0][7:0] col_t;

	// One pixel job handed from the window front end to the normal unit.
	typedef struct packed {
		col_t lft;
		col_t ctr;
		col_t rgt;
		logic eor;
		logic eof;
	} job_t;

	localparam logic [7:0] BYTE_FULL = 8'd255;

endpackage

/* sv/sobel_height_to_normal_map.sv */
// Top level of the Sobel height-to-normal-map block with its register port.
//
// Height samples enter on the sample channel (sample_valid, sample_stall) with
// func = 0; a func = 1 item is a drain tick that releases one pixel of the
// bottom row once the last row has been taken. Normal pixels leave on the
// result channel (result_valid, result_stall) one transfer at a time, one
// row and one column behind the samples, up to two per sample item.
// image_width and image_height are written over the APB-style port at byte
// addresses 0 and 4; write them only while idle, the block does not enforce it.
// One item is taken at a time: a sample item passes through the line store
// read and the write-back, a drain tick through three store reads.
// Each pixel then passes through the normal unit, with its 55-step restoring
// division and 20-step square root; an item with two pixels goes through it
// twice. The next item is accepted once the last pixel has been handed to
// the normal unit, while the result waits.
// A stalled result holds in the output register and holds back later items.
// Reset clears all counters and the registers return to 256 by 256; the
// line stores need no clearing.
`timescale 1ns / 1ps
module sobel_height_to_normal_map #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic        func,
	input  logic [7:0]  height_sample,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  normal_red,
	output logic [7:0]  normal_green,
	output logic [7:0]  normal_blue,
	output logic [7:0]  alpha_value,
	output logic        end_of_run,
	output logic        end_of_frame
);
	import snm_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	logic [12:0] width_q;
	logic [15:0] height_q;
	logic [AW-1:0] wm1;
	logic [15:0] hgt;
	logic job_valid, job_take;
	job_t job;

	// Configuration registers, written on the access cycle of a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd256;
			height_q <= 16'd256;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WIDTH:  width_q <= pwdata[12:0];
				REG_HEIGHT: height_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {16'b0, height_q} : {19'b0, width_q};

	// Effective last column and row count.
	always_comb begin
		if (width_q == 13'd0) wm1 = '0;
		else if (32'(width_q) > MAX_WIDTH) wm1 = AW'(MAX_WIDTH - 1);
		else wm1 = AW'(width_q - 13'd1);
		hgt = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	snm_front #(
		.Depth(MAX_WIDTH),
		.AddrW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.func(func),
		.height_sample(height_sample),
		.wm1(wm1),
		.hgt(hgt),
		.job_valid(job_valid),
		.job(job),
		.job_take(job_take)
	);

	snm_normal u_normal (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(job),
		.job_take(job_take),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.normal_red(normal_red),
		.normal_green(normal_green),
		.normal_blue(normal_blue),
		.end_of_run(end_of_run),
		.end_of_frame(end_of_frame)
	);

	assign alpha_value = BYTE_FULL;

endmodule

/* sv/snm_front.sv */
// Line stores, 3x3 window and pixel job sequencer of the normal-map block.
`timescale 1ns / 1ps
module snm_front #(
	parameter int Depth = 4096,
	parameter int AddrW = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  logic              func,
	input  logic [7:0]        height_sample,
	input  logic [AddrW-1:0]  wm1,
	input  logic [15:0]       hgt,
	output logic              job_valid,
	output snm_pkg::job_t     job,
	input  logic              job_take
);
	import snm_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE,
		F_WB,
		F_DL,
		F_DC,
		F_DR,
		F_JOB
	} fstate_t;

	fstate_t state_q;

	logic [7:0] m1_mem [Depth];
	logic [7:0] m2_mem [Depth];
	logic [7:0] m1_rd_q;
	logic [7:0] m2_rd_q;
	logic [AddrW-1:0] rd_addr;

	logic [AddrW-1:0] col_q;
	logic [15:0] row_q;
	logic [AddrW-1:0] drain_q;
	logic [AddrW-1:0] x_q;
	logic [AddrW-1:0] dc_q;
	logic [AddrW-1:0] dr_q;
	logic [7:0] s_q;
	logic y1_q, xge1_q, xge2_q, j1_q, j2_q, drn_q, eof_q;
	col_t win_q [3];

	logic [AddrW-1:0] x_cl, dc, dl, dr;
	logic accept, last, h_ge2;
	logic [7:0] top_rd;
	col_t lc, cc, rc;

	// Clamp the running positions to the current width.
	always_comb begin
		x_cl = (col_q > wm1) ? wm1 : col_q;
		dc = (drain_q > wm1) ? wm1 : drain_q;
		dl = (dc == '0) ? '0 : dc - 1'b1;
		dr = (dc == wm1) ? wm1 : dc + 1'b1;
		last = (x_q == wm1);
		h_ge2 = (hgt >= 16'd2);
		top_rd = h_ge2 ? m2_rd_q : m1_rd_q;
	end

	assign sample_stall = (state_q != F_IDLE);
	assign accept = sample_valid && (state_q == F_IDLE);

	// Read address follows the sequencer step.
	always_comb begin
		case (state_q)
			F_IDLE:  rd_addr = func ? dl : x_cl;
			F_DL:    rd_addr = dc_q;
			F_DC:    rd_addr = dr_q;
			default: rd_addr = x_q;
		endcase
	end

	// Line stores: one read and one write port each, registered read data.
	always_ff @(posedge clk) begin
		m1_rd_q <= m1_mem[rd_addr];
		m2_rd_q <= m2_mem[rd_addr];
		if (state_q == F_WB) begin
			m1_mem[x_q] <= s_q;
			m2_mem[x_q] <= m1_rd_q;
		end
	end

	// Window columns: shifted by samples, loaded from the stores when draining.
	always_ff @(posedge clk) begin
		case (state_q)
			F_WB: begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= {s_q, m1_rd_q, m2_rd_q};
			end
			F_DL:    win_q[0] <= {m1_rd_q, m1_rd_q, top_rd};
			F_DC:    win_q[1] <= {m1_rd_q, m1_rd_q, top_rd};
			F_DR:    win_q[2] <= {m1_rd_q, m1_rd_q, top_rd};
			default: ;
		endcase
	end

	// Sequencer, counters and per-item flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q <= '0;
			row_q <= '0;
			drain_q <= '0;
			x_q <= '0;
			dc_q <= '0;
			dr_q <= '0;
			s_q <= '0;
			y1_q <= 1'b0;
			xge1_q <= 1'b0;
			xge2_q <= 1'b0;
			j1_q <= 1'b0;
			j2_q <= 1'b0;
			drn_q <= 1'b0;
			eof_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (!func) begin
							if (row_q < hgt) begin
								x_q <= x_cl;
								s_q <= height_sample;
								state_q <= F_WB;
							end
						end else if (row_q >= hgt) begin
							dc_q <= dc;
							dr_q <= dr;
							eof_q <= (dc == wm1);
							drn_q <= 1'b1;
							j1_q <= 1'b1;
							j2_q <= 1'b0;
							if (dc == wm1) begin
								col_q <= '0;
								row_q <= '0;
								drain_q <= '0;
							end else begin
								drain_q <= dc + 1'b1;
							end
							state_q <= F_DL;
						end
					end
				end
				F_WB: begin
					drn_q <= 1'b0;
					y1_q <= (row_q == 16'd1);
					xge1_q <= (x_q != '0);
					xge2_q <= (x_q > AddrW'(1));
					j1_q <= (row_q != '0) && (x_q != '0);
					j2_q <= (row_q != '0) && last;
					if (last) begin
						col_q <= '0;
						row_q <= row_q + 16'd1;
					end else begin
						col_q <= x_q + 1'b1;
					end
					state_q <= ((row_q != '0) && ((x_q != '0) || last)) ? F_JOB : F_IDLE;
				end
				F_DL: state_q <= F_DC;
				F_DC: state_q <= F_DR;
				F_DR: state_q <= F_JOB;
				F_JOB: begin
					if (job_take) begin
						if (j1_q) begin
							j1_q <= 1'b0;
							if (!j2_q) state_q <= F_IDLE;
						end else begin
							j2_q <= 1'b0;
							state_q <= F_IDLE;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Pick the three columns of the pending pixel, clamping the left, right and top edges.
	always_comb begin
		job.eof = 1'b0;
		job.eor = 1'b1;
		if (drn_q) begin
			lc = win_q[0];
			cc = win_q[1];
			rc = win_q[2];
			job.eof = eof_q;
		end else if (j1_q) begin
			lc = xge2_q ? win_q[0] : win_q[1];
			cc = win_q[1];
			rc = win_q[2];
			job.eor = !j2_q;
		end else begin
			lc = xge1_q ? win_q[1] : win_q[2];
			cc = win_q[2];
			rc = win_q[2];
		end
		if (!drn_q && y1_q) begin
			lc[0] = lc[1];
			cc[0] = cc[1];
			rc[0] = rc[1];
		end
		job.lft = lc;
		job.ctr = cc;
		job.rgt = rc;
	end

	assign job_valid = (state_q == F_JOB);

endmodule

/* sv/snm_normal.sv */
// Iterative normal unit: Sobel gradients, reciprocal square root, byte mapping.
`timescale 1ns / 1ps
module snm_normal (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  snm_pkg::job_t job,
	output logic          job_take,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [7:0]    normal_red,
	output logic [7:0]    normal_green,
	output logic [7:0]    normal_blue,
	output logic          end_of_run,
	output logic          end_of_frame
);
	import snm_pkg::*;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SQ,
		N_SUM,
		N_DIV,
		N_SQRT,
		N_MUL,
		N_MAP,
		N_OUT
	} nstate_t;

	nstate_t state_q;
	logic signed [11:0] dx_q, dy_q;
	logic [20:0] sq_q;
	logic [21:0] s_q;
	logic [21:0] rem_q;
	logic [39:0] q_q;
	logic [20:0] srem_q;
	logic [19:0] root_q;
	logic [5:0] cnt_q;
	logic [1:0] k_q;
	logic signed [32:0] prod_q;
	logic [7:0] byte_q [3];
	logic eor_q, eof_q;

	logic [9:0] sum_r, sum_l, sum_b, sum_t;
	logic signed [23:0] sqx, sqy;
	logic [22:0] s_full;
	logic [22:0] dsh;
	logic dge;
	logic [22:0] sn, trial;
	logic sge;
	logic signed [11:0] vsel;
	logic signed [32:0] nfix;
	logic [17:0] t18;
	logic [25:0] b26;

	// Weighted column and row sums of the window.
	always_comb begin
		sum_r = {2'b0, job.rgt[0]} + {1'b0, job.rgt[1], 1'b0} + {2'b0, job.rgt[2]};
		sum_l = {2'b0, job.lft[0]} + {1'b0, job.lft[1], 1'b0} + {2'b0, job.lft[2]};
		sum_b = {2'b0, job.lft[2]} + {1'b0, job.ctr[2], 1'b0} + {2'b0, job.rgt[2]};
		sum_t = {2'b0, job.lft[0]} + {1'b0, job.ctr[0], 1'b0} + {2'b0, job.rgt[0]};
	end

	// Squares and the restoring steps for division and square root.
	always_comb begin
		sqx = dx_q * dx_q;
		sqy = dy_q * dy_q;
		s_full = {2'b0, sq_q} + {1'b0, sqy[21:0]} + 23'd65025;
		dsh = {rem_q, (cnt_q == 6'd54)};
		dge = (dsh >= {1'b0, s_q});
		sn = {srem_q, q_q[39:38]};
		trial = {1'b0, root_q, 2'b01};
		sge = (sn >= trial);
	end

	// Component select and mapping of the scaled product to a byte.
	always_comb begin
		case (k_q)
			2'd0:    vsel = -dx_q;
			2'd1:    vsel = -dy_q;
			default: vsel = 12'sd255;
		endcase
		nfix = (prod_q >>> 11) + 33'sd65536;
		t18 = nfix[17:0];
		b26 = {t18, 8'b0} - {8'b0, t18};
	end

	assign job_take = job_valid && (state_q == N_IDLE);
	assign result_valid = (state_q == N_OUT);

	// Sequencer over gradient, 55 division steps, 20 root steps and three products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q <= '0;
			k_q <= '0;
		end else begin
			case (state_q)
				N_IDLE: if (job_take) state_q <= N_SQ;
				N_SQ: state_q <= N_SUM;
				N_SUM: begin
					cnt_q <= 6'd54;
					state_q <= N_DIV;
				end
				N_DIV: begin
					if (cnt_q == '0) begin
						cnt_q <= 6'd19;
						state_q <= N_SQRT;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				N_SQRT: begin
					if (cnt_q == '0) begin
						k_q <= '0;
						state_q <= N_MUL;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				N_MUL: state_q <= N_MAP;
				N_MAP: begin
					if (k_q == 2'd2) begin
						state_q <= N_OUT;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= N_MUL;
					end
				end
				N_OUT: if (!result_stall) state_q <= N_IDLE;
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (job_take) begin
					dx_q <= $signed({2'b0, sum_r}) - $signed({2'b0, sum_l});
					dy_q <= $signed({2'b0, sum_b}) - $signed({2'b0, sum_t});
					eor_q <= job.eor;
					eof_q <= job.eof;
				end
			end
			N_SQ: sq_q <= sqx[20:0];
			N_SUM: begin
				s_q <= s_full[21:0];
				rem_q <= '0;
				q_q <= '0;
			end
			N_DIV: begin
				q_q <= {q_q[38:0], dge};
				rem_q <= dge ? 22'(dsh - {1'b0, s_q}) : dsh[21:0];
				srem_q <= '0;
				root_q <= '0;
			end
			N_SQRT: begin
				q_q <= {q_q[37:0], 2'b00};
				srem_q <= sge ? 21'(sn - trial) : sn[20:0];
				root_q <= {root_q[18:0], sge};
			end
			N_MUL: prod_q <= vsel * $signed({1'b0, root_q});
			N_MAP: byte_q[k_q] <= b26[24:17];
			default: ;
		endcase
	end

	assign normal_red = byte_q[0];
	assign normal_green = byte_q[1];
	assign normal_blue = byte_q[2];
	assign end_of_run = eor_q;
	assign end_of_frame = eof_q;

endmodule
